@@ rtl/oef_pkg.sv @@
// Package for the one euro filter: divider request/response types, fixed
// arithmetic constants and configuration register indexes. No dependencies.
package oef_pkg;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 36;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  // 2*pi in Q3.29 and one second in microseconds, Q16.16
  localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
  localparam logic [36:0] US_PER_S_Q16 = 37'd65536000000;

  localparam logic [1:0] CFG_INIT_RATE  = 2'd0;
  localparam logic [1:0] CFG_MIN_CUTOFF = 2'd1;
  localparam logic [1:0] CFG_SPEED_GAIN = 2'd2;
  localparam logic [1:0] CFG_DERIV_CUT  = 2'd3;

endpackage

@@ rtl/oef_div.sv @@
// Restoring divider for the one euro filter, one quotient bit per cycle.
// Depends on oef_pkg for the request and response types.
module oef_div (
  input  logic             clk,
  input  logic             rst_n,
  input  oef_pkg::div_req_t req,
  output oef_pkg::div_rsp_t rsp
);

  localparam int NW = oef_pkg::DIV_NUM_W;
  localparam int DW = oef_pkg::DIV_DEN_W;
  localparam int CW = oef_pkg::DIV_CNT_W;

  logic          busy_r, done_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r, den_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, q_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r    <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        q_r   <= {q_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

@@ rtl/one_euro_filter_vec3.sv @@
// One euro filter, three axes, top level.
// Depends on oef_pkg and oef_div.
//
// Usage:
//   Input items (x, y, z sample, timestamp, timestamp-known flag) enter on the
//   in_ valid/ready channel; one filtered item leaves on the out_ channel for
//   every input item. cfg_we writes one of four Q16.16 registers by index
//   (initial rate, minimum cutoff, speed gain, derivative cutoff); write only
//   while the block is idle.
//   A filtered item runs the restoring divider once for the rate when a new
//   rate is measured and, unless the denominator is zero, once for each of
//   the two smoothing factors; the integer square root and the shared
//   multiplier (15 uses) add the rest. An item in pass-through (infinite
//   rate) skips all of these. One item is worked on at a time; in_ready is
//   high only in idle.
//   The output register holds a finished item while the receiver stalls; the
//   next item is accepted meanwhile but is not finished until that slot frees.
//   Reset (rst_n low, synchronous) loads the register defaults, clears the
//   filter history and the primed flag, and drops any pending output.
module one_euro_filter_vec3 #(
  parameter int SAMPLE_FRAC_BITS = 16,
  parameter int ALPHA_FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_sample_x,
  input  logic signed [31:0] in_sample_y,
  input  logic signed [31:0] in_sample_z,
  input  logic [31:0]        in_time_us,
  input  logic               in_time_known,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_passed_raw,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int SF = SAMPLE_FRAC_BITS;
  localparam int AF = ALPHA_FRAC_BITS;
  localparam int AW = AF + 1;
  localparam logic [36:0] US_PER_S_Q16_C = oef_pkg::US_PER_S_Q16;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_RATE  = 11'b000_0000_0010,
    ST_WMUL  = 11'b000_0000_0100,
    ST_ADIV  = 11'b000_0000_1000,
    ST_DMUL  = 11'b000_0001_0000,
    ST_EMUL  = 11'b000_0010_0000,
    ST_SQMUL = 11'b000_0100_0000,
    ST_SQRT  = 11'b000_1000_0000,
    ST_CMUL  = 11'b001_0000_0000,
    ST_XMUL  = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  // configuration
  logic [31:0] min_cut_r, gain_r, dcut_r;

  // filter history
  logic [31:0] prev_time_r, prev_time_nxt;
  logic        prev_tk_r, prev_tk_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic        rate_inf_r, rate_inf_nxt;
  logic        primed_r, primed_nxt;
  logic signed [31:0] prev_raw_r [3], prev_raw_nxt [3];
  logic signed [31:0] prev_smooth_r [3], prev_smooth_nxt [3];
  logic signed [31:0] prev_speed_r [3], prev_speed_nxt [3];

  // item and working registers
  state_t             state_r, state_nxt;
  logic signed [31:0] x_r [3], x_nxt [3];
  logic signed [31:0] ed_r [3], ed_nxt [3];
  logic signed [31:0] res_r [3], res_nxt [3];
  logic signed [31:0] dv_r, dv_nxt;
  logic [AW-1:0]      alpha_r, alpha_nxt;
  logic [35:0]        w_r, w_nxt;
  logic [63:0]        sumsq_r, sumsq_nxt;
  logic [63:0]        root_r, root_nxt;
  logic [63:0]        bit_r, bit_nxt;
  logic [31:0]        speed_r, speed_nxt;
  logic [31:0]        cut_r, cut_nxt;
  logic [32:0]        mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic [65:0]        prod_r;
  logic [1:0]         ph_r, ph_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic               asel_r, asel_nxt;
  logic               raw_r, raw_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_r [3];
  logic               out_raw_r;
  logic               out_load;

  oef_pkg::div_req_t div_req;
  oef_pkg::div_rsp_t div_rsp;

  oef_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // prev moved toward the new value by the rounded product |new-prev|*alpha
  function automatic logic signed [31:0] blend_fin(input logic signed [31:0] prev,
                                                   input logic neg,
                                                   input logic [65:0] p);
    logic [65:0]        rnd;
    logic signed [34:0] pv, rv;
    rnd = (p + (66'd1 << (AF - 1))) >> AF;
    pv  = 35'(prev);
    rv  = $signed({1'b0, rnd[33:0]});
    return sat32(neg ? pv - rv : pv + rv);
  endfunction

  logic               accept;
  logic [31:0]        dt;
  logic signed [31:0] cur_x, cur_praw, cur_psm, cur_psp, cur_ed;
  logic signed [32:0] d_raw, d_e, d_x;
  logic [32:0]        m_raw, m_e, m_x, m_ed;
  logic [65:0]        q_der;
  logic [32:0]        q_clip;
  logic [35:0]        den_a;
  logic [64:0]        w_sum;
  logic [64:0]        c_rnd;
  logic [64:0]        c_sum;
  logic [63:0]        sq_try;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign dt       = in_time_us - prev_time_r;

  assign cur_x    = x_r[axis_r];
  assign cur_praw = prev_raw_r[axis_r];
  assign cur_psm  = prev_smooth_r[axis_r];
  assign cur_psp  = prev_speed_r[axis_r];
  assign cur_ed   = ed_r[axis_r];

  assign d_raw = 33'(cur_x) - 33'(cur_praw);
  assign d_e   = 33'(dv_r) - 33'(cur_psp);
  assign d_x   = 33'(cur_x) - 33'(cur_psm);
  assign m_raw = d_raw[32] ? 33'(-d_raw) : 33'(d_raw);
  assign m_e   = d_e[32] ? 33'(-d_e) : 33'(d_e);
  assign m_x   = d_x[32] ? 33'(-d_x) : 33'(d_x);
  assign m_ed  = cur_ed[31] ? 33'(-33'(cur_ed)) : 33'(cur_ed);

  assign q_der  = (prod_r + 66'd32768) >> 16;
  assign q_clip = (q_der > 66'h1_0000_0000) ? 33'h1_0000_0000 : q_der[32:0];
  assign den_a  = 36'(37'(w_r) + 37'(rate_r));
  assign w_sum  = (65'(prod_r[63:0]) + 65'd268435456) >> 29;
  assign c_rnd  = (65'(prod_r[63:0]) + (65'd1 << (SF - 1))) >> SF;
  assign c_sum  = c_rnd + 65'(min_cut_r);
  assign sq_try = root_r + bit_r;

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    prev_time_nxt = prev_time_r;
    prev_tk_nxt   = prev_tk_r;
    rate_nxt      = rate_r;
    rate_inf_nxt  = rate_inf_r;
    primed_nxt    = primed_r;
    prev_raw_nxt    = prev_raw_r;
    prev_smooth_nxt = prev_smooth_r;
    prev_speed_nxt  = prev_speed_r;
    x_nxt     = x_r;
    ed_nxt    = ed_r;
    res_nxt   = res_r;
    dv_nxt    = dv_r;
    alpha_nxt = alpha_r;
    w_nxt     = w_r;
    sumsq_nxt = sumsq_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    speed_nxt = speed_r;
    cut_nxt   = cut_r;
    mul_a_nxt = mul_a_r;
    mul_b_nxt = mul_b_r;
    ph_nxt    = ph_r;
    axis_nxt  = axis_r;
    asel_nxt  = asel_r;
    raw_nxt   = raw_r;
    div_req.start = 1'b0;
    div_req.num   = (64'(w_r) << AF) + 64'(den_a >> 1);
    div_req.den   = den_a;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_nxt[0] = in_sample_x;
          x_nxt[1] = in_sample_y;
          x_nxt[2] = in_sample_z;
          prev_time_nxt = in_time_us;
          prev_tk_nxt   = in_time_known;
          asel_nxt = 1'b0;
          ph_nxt   = 2'd0;
          if (prev_tk_r && in_time_known && dt != 32'd0) begin
            div_req.start = 1'b1;
            div_req.num   = 64'(US_PER_S_Q16_C) + 64'(dt[31:1]);
            div_req.den   = 36'(dt);
            state_nxt     = ST_RATE;
          end else if ((prev_tk_r && in_time_known) || rate_inf_r) begin
            // equal timestamps, or rate still infinite: echo the raw sample
            rate_inf_nxt = 1'b1;
            raw_nxt      = 1'b1;
            state_nxt    = ST_OUT;
          end else begin
            raw_nxt   = 1'b0;
            state_nxt = ST_WMUL;
          end
        end
      end
      ST_RATE: begin
        if (div_rsp.done) begin
          rate_nxt     = (div_rsp.quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                        : div_rsp.quot[31:0];
          rate_inf_nxt = 1'b0;
          raw_nxt      = 1'b0;
          state_nxt    = ST_WMUL;
        end
      end
      ST_WMUL: begin
        case (ph_r)
          2'd0: begin
            mul_a_nxt = 33'(asel_r ? cut_r : dcut_r);
            mul_b_nxt = 33'(oef_pkg::TWO_PI_Q29);
            ph_nxt    = 2'd1;
          end
          2'd1: ph_nxt = 2'd2;
          default: begin
            w_nxt     = w_sum[35:0];
            ph_nxt    = 2'd0;
            state_nxt = ST_ADIV;
          end
        endcase
      end
      ST_ADIV: begin
        if (ph_r == 2'd0) begin
          if (den_a == 36'd0) begin
            alpha_nxt = AW'(1) << AF;
            ph_nxt    = 2'd2;
          end else begin
            div_req.start = 1'b1;
            ph_nxt        = 2'd1;
          end
        end else if (ph_r == 2'd1) begin
          if (div_rsp.done) begin
            alpha_nxt = div_rsp.quot[AW-1:0];
            ph_nxt    = 2'd2;
          end
        end else begin
          ph_nxt    = 2'd0;
          axis_nxt  = 2'd0;
          sumsq_nxt = 64'd0;
          state_nxt = asel_r ? ST_XMUL : ST_DMUL;
        end
      end
      ST_DMUL: begin
        case (ph_r)
          2'd0: begin
            mul_a_nxt = m_raw;
            mul_b_nxt = 33'(rate_r);
            ph_nxt    = 2'd1;
          end
          2'd1: ph_nxt = 2'd2;
          default: begin
            dv_nxt    = primed_r ? sat32(d_raw[32] ? -35'($signed({2'b0, q_clip}))
                                                   : 35'($signed({2'b0, q_clip})))
                                 : 32'sd0;
            ph_nxt    = 2'd0;
            state_nxt = ST_EMUL;
          end
        endcase
      end
      ST_EMUL: begin
        case (ph_r)
          2'd0: begin
            mul_a_nxt = m_e;
            mul_b_nxt = 33'(alpha_r);
            ph_nxt    = 2'd1;
          end
          2'd1: ph_nxt = 2'd2;
          default: begin
            ed_nxt[axis_r] = primed_r ? blend_fin(cur_psp, d_e[32], prod_r) : dv_r;
            ph_nxt    = 2'd0;
            state_nxt = ST_SQMUL;
          end
        endcase
      end
      ST_SQMUL: begin
        case (ph_r)
          2'd0: begin
            mul_a_nxt = m_ed;
            mul_b_nxt = m_ed;
            ph_nxt    = 2'd1;
          end
          2'd1: ph_nxt = 2'd2;
          default: begin
            sumsq_nxt = sumsq_r + prod_r[63:0];
            ph_nxt    = 2'd0;
            if (axis_r == 2'd2) begin
              root_nxt  = 64'd0;
              bit_nxt   = 64'd1 << 62;
              state_nxt = ST_SQRT;
            end else begin
              axis_nxt  = axis_r + 2'd1;
              state_nxt = ST_DMUL;
            end
          end
        endcase
      end
      ST_SQRT: begin
        // one result bit a cycle; sumsq holds the shrinking remainder
        if (bit_r == 64'd0) begin
          speed_nxt = root_r[31:0];
          state_nxt = ST_CMUL;
        end else begin
          if (sumsq_r >= sq_try) begin
            sumsq_nxt = sumsq_r - sq_try;
            root_nxt  = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      ST_CMUL: begin
        case (ph_r)
          2'd0: begin
            mul_a_nxt = 33'(gain_r);
            mul_b_nxt = 33'(speed_r);
            ph_nxt    = 2'd1;
          end
          2'd1: ph_nxt = 2'd2;
          default: begin
            cut_nxt   = (c_sum > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : c_sum[31:0];
            asel_nxt  = 1'b1;
            ph_nxt    = 2'd0;
            state_nxt = ST_WMUL;
          end
        endcase
      end
      ST_XMUL: begin
        case (ph_r)
          2'd0: begin
            mul_a_nxt = m_x;
            mul_b_nxt = 33'(alpha_r);
            ph_nxt    = 2'd1;
          end
          2'd1: ph_nxt = 2'd2;
          default: begin
            res_nxt[axis_r] = primed_r ? blend_fin(cur_psm, d_x[32], prod_r) : cur_x;
            ph_nxt = 2'd0;
            if (axis_r == 2'd2) begin
              state_nxt = ST_OUT;
            end else begin
              axis_nxt = axis_r + 2'd1;
            end
          end
        endcase
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (!raw_r) begin
            prev_raw_nxt    = x_r;
            prev_smooth_nxt = res_r;
            prev_speed_nxt  = ed_r;
            primed_nxt      = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_cut_r   <= 32'd65536;
      gain_r      <= 32'd0;
      dcut_r      <= 32'd65536;
      prev_time_r <= 32'd0;
      prev_tk_r   <= 1'b0;
      rate_r      <= 32'd3932160;
      rate_inf_r  <= 1'b0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ph_r        <= 2'd0;
      axis_r      <= 2'd0;
      asel_r      <= 1'b0;
      raw_r       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_raw_r[i]    <= 32'sd0;
        prev_smooth_r[i] <= 32'sd0;
        prev_speed_r[i]  <= 32'sd0;
      end
    end else begin
      state_r     <= state_nxt;
      prev_time_r <= prev_time_nxt;
      prev_tk_r   <= prev_tk_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
      axis_r      <= axis_nxt;
      asel_r      <= asel_nxt;
      raw_r       <= raw_nxt;
      prev_raw_r    <= prev_raw_nxt;
      prev_smooth_r <= prev_smooth_nxt;
      prev_speed_r  <= prev_speed_nxt;
      // writing the initial rate also restarts the measured rate
      if (cfg_we && cfg_index == oef_pkg::CFG_INIT_RATE) begin
        rate_r      <= cfg_data;
        rate_inf_r  <= 1'b0;
      end else begin
        rate_r     <= rate_nxt;
        rate_inf_r <= rate_inf_nxt;
      end
      if (cfg_we && cfg_index == oef_pkg::CFG_MIN_CUTOFF) min_cut_r <= cfg_data;
      if (cfg_we && cfg_index == oef_pkg::CFG_SPEED_GAIN) gain_r <= cfg_data;
      if (cfg_we && cfg_index == oef_pkg::CFG_DERIV_CUT) dcut_r <= cfg_data;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    ed_r    <= ed_nxt;
    res_r   <= res_nxt;
    dv_r    <= dv_nxt;
    alpha_r <= alpha_nxt;
    w_r     <= w_nxt;
    sumsq_r <= sumsq_nxt;
    root_r  <= root_nxt;
    bit_r   <= bit_nxt;
    speed_r <= speed_nxt;
    cut_r   <= cut_nxt;
    mul_a_r <= mul_a_nxt;
    mul_b_r <= mul_b_nxt;
    prod_r  <= mul_a_r * mul_b_r;
    if (out_load) begin
      out_r     <= raw_r ? x_r : res_r;
      out_raw_r <= raw_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_r[0];
  assign out_y          = out_r[1];
  assign out_z          = out_r[2];
  assign out_passed_raw = out_raw_r;

  // the divider is never restarted while it is still working
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // smoothing factor never exceeds one when the blend uses it
  a_alpha_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_XMUL || state_r == ST_EMUL) |-> alpha_r <= (AW'(1) << AF))
    else $error("alpha above one");

  // a raw pass-through leaves the filter history untouched
  a_raw_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && raw_r) |=> (primed_r == $past(primed_r)
                             && prev_smooth_r[0] == $past(prev_smooth_r[0])))
    else $error("history changed on raw pass-through");

  // a new result is loaded only when the output slot is free
  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output overwritten while stalled");

endmodule

@@ test/testbench.sv @@
// Self-checking bench for one_euro_filter_vec3: drives sample items with
// timestamps, predicts each filtered item in SystemVerilog, compares fields.
// Depends on oef_pkg and the one_euro_filter_vec3 RTL.
module testbench;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [31:0]        t;
    logic               tk;
  } sample_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               raw;
  } smooth_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_sample_x = '0, in_sample_y = '0, in_sample_z = '0;
  logic [31:0] in_time_us = '0;
  logic in_time_known = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic out_passed_raw;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  one_euro_filter_vec3 i_dut (.*);

  always #4 clk = ~clk;

  // filter state as the bench sees it
  logic [31:0] r_min_cut, r_gain, r_dcut;
  logic [31:0] last_time, cur_rate;
  logic        last_time_known, rate_infinite, history_valid;
  logic signed [31:0] last_raw[3], last_smooth[3], last_speed[3];

  sample_t pending_items[$];
  smooth_t expected_items[$];
  int      errors = 0, accepted = 0, checked = 0, raw_seen = 0;
  int      send_idle_pct = 0, recv_stall_pct = 0;
  bit      hold_off = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on item %0d, %s: got %h expected %h", checked, what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] alpha_for(input logic [31:0] cutoff);
    logic [63:0] w, den;
    w = ({32'd0, cutoff} * {32'd0, oef_pkg::TWO_PI_Q29} + 64'd268435456) >> 29;
    den = w + {32'd0, cur_rate};
    if (den == 0) return 64'd65536;
    return ((w << 16) + den / 2) / den;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] mix(input logic signed [31:0] prv,
                                             input logic signed [31:0] cur,
                                             input logic [63:0] a);
    logic signed [63:0] d;
    logic [63:0] m, r;
    d = 64'(cur) - 64'(prv);
    m = d < 0 ? -d : d;
    r = (m * a + 64'd32768) >> 16;
    return sat32(d < 0 ? 64'(prv) - $signed(r) : 64'(prv) + $signed(r));
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // advance the predicted state by one item and return the filtered item
  function automatic smooth_t predict_smooth(input sample_t s);
    smooth_t o;
    logic signed [31:0] xs[3], es[3], dv;
    logic signed [63:0] diff, e;
    logic [63:0] m, q, ad, ax, sumsq, cut;
    logic [31:0] dt;
    xs[0] = s.x; xs[1] = s.y; xs[2] = s.z;
    if (last_time_known && s.tk) begin
      dt = s.t - last_time;
      if (dt == 0) rate_infinite = 1'b1;
      else begin
        q = ({27'd0, oef_pkg::US_PER_S_Q16} + dt / 2) / dt;
        cur_rate = q > 64'hffffffff ? 32'hffffffff : q[31:0];
        rate_infinite = 1'b0;
      end
    end
    last_time = s.t;
    last_time_known = s.tk;
    o.x = s.x; o.y = s.y; o.z = s.z; o.raw = 1'b1;
    if (rate_infinite) return o;
    ad = alpha_for(r_dcut);
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      dv = 0;
      if (history_valid) begin
        diff = 64'(xs[i]) - 64'(last_raw[i]);
        m = diff < 0 ? -diff : diff;
        q = (m * {32'd0, cur_rate} + 64'd32768) >> 16;
        if (q > 64'h100000000) q = 64'h100000000;
        dv = sat32(diff < 0 ? -$signed(q) : $signed(q));
      end
      es[i] = history_valid ? mix(last_speed[i], dv, ad) : dv;
      e = es[i];
      m = e < 0 ? -e : e;
      sumsq += m * m;
    end
    cut = ({32'd0, r_gain} * root64(sumsq) + 64'd32768) >> 16;
    cut += r_min_cut;
    if (cut > 64'hffffffff) cut = 64'hffffffff;
    ax = alpha_for(cut[31:0]);
    for (int i = 0; i < 3; i++) begin
      xs[i] = history_valid ? mix(last_smooth[i], xs[i], ax) : xs[i];
      last_speed[i] = es[i];
      last_raw[i] = i == 0 ? s.x : (i == 1 ? s.y : s.z);
      last_smooth[i] = xs[i];
    end
    history_valid = 1'b1;
    o.x = xs[0]; o.y = xs[1]; o.z = xs[2]; o.raw = 1'b0;
    return o;
  endfunction

  // driver: present the next pending item, hold it until accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_items.push_back(predict_smooth('{in_sample_x, in_sample_y, in_sample_z,
                                                  in_time_us, in_time_known}));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_t s;
          s = pending_items.pop_front();
          in_valid <= 1'b1;
          in_sample_x <= s.x; in_sample_y <= s.y; in_sample_z <= s.z;
          in_time_us <= s.t; in_time_known <= s.tk;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_items.size() == 0) begin
          report("result with no item outstanding", out_x, 32'd0);
        end else begin
          smooth_t w;
          w = expected_items.pop_front();
          if (out_x !== w.x) report("x", out_x, w.x);
          if (out_y !== w.y) report("y", out_y, w.y);
          if (out_z !== w.z) report("z", out_z, w.z);
          if (out_passed_raw !== w.raw) report("passed_raw", out_passed_raw, w.raw);
          if (w.raw) raw_seen++;
          checked++;
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one write, with cfg_we dropped again afterwards so back-to-back writes never collide
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      oef_pkg::CFG_INIT_RATE: begin
        cur_rate = v; rate_infinite = 1'b0;
      end
      oef_pkg::CFG_MIN_CUTOFF: r_min_cut = v;
      oef_pkg::CFG_SPEED_GAIN: r_gain = v;
      oef_pkg::CFG_DERIV_CUT:  r_dcut = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait until every queued item has been answered, then let the block settle
  task automatic drain;
    while (pending_items.size() > 0 || in_valid || expected_items.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1, 0) ? 32'h7fffffff - $urandom_range(4) : 32'h80000000 + $urandom_range(4);
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  // a run of well-formed samples: steady steps, an occasional repeat, jump or lost time
  task automatic add_track(input int n);
    logic [31:0] t, x, y, z, step;
    t = $urandom();
    x = rand_coord(); y = rand_coord(); z = rand_coord();
    step = $urandom_range(3) == 0 ? $urandom() : $urandom_range(2000, 40000);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: ;                         // same time again: infinite rate
        1: t = $urandom();
        default: t = t + step + $urandom_range(50);
      endcase
      x += $signed($urandom_range(200000)) - 100000;
      y += $signed($urandom_range(200000)) - 100000;
      z += $signed($urandom_range(200000)) - 100000;
      if ($urandom_range(9) == 0) x = rand_coord();
      pending_items.push_back('{x, y, z, t, $urandom_range(15) != 0});
    end
  endtask

  task automatic random_phase(input int sidle, input int rstall, input int n);
    send_idle_pct = sidle; recv_stall_pct = rstall;
    while (n > 0) begin
      int len;
      len = $urandom_range(5, 30);
      add_track(len);
      n -= len;
    end
    drain();
  endtask

  initial begin
    r_min_cut = 32'd65536; r_gain = 0; r_dcut = 32'd65536;
    cur_rate = 32'd3932160; rate_infinite = 0; history_valid = 0;
    last_time = 0; last_time_known = 0;
    for (int i = 0; i < 3; i++) begin
      last_raw[i] = 0; last_smooth[i] = 0; last_speed[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first item, extremes, repeated time, unknown time, wrap
    pending_items.push_back('{32'h7fffffff, 32'h80000000, 32'd0, 32'd100, 1'b1});
    pending_items.push_back('{32'h80000000, 32'h7fffffff, 32'hffffffff, 32'd16767, 1'b1});
    pending_items.push_back('{32'h00010000, 32'hffff0000, 32'd1, 32'd16767, 1'b1});
    pending_items.push_back('{32'h00020000, 32'h0, 32'd5, 32'd16767, 1'b1});
    pending_items.push_back('{32'h00030000, 32'h0, 32'd5, 32'd16768, 1'b1});
    pending_items.push_back('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0});
    pending_items.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 32'hfffffff0, 1'b1});
    pending_items.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h00000010, 1'b1});
    pending_items.push_back('{32'h0, 32'h0, 32'h0, 32'hffffffff, 1'b1});
    pending_items.push_back('{32'h12345678, 32'hedcba987, 32'h0, 32'h0, 1'b1});
    drain();

    // extremes of the registers, including zero values outside the range
    write_reg(oef_pkg::CFG_INIT_RATE, 32'hffffffff);
    write_reg(oef_pkg::CFG_MIN_CUTOFF, 32'hffffffff);
    write_reg(oef_pkg::CFG_SPEED_GAIN, 32'hffffffff);
    write_reg(oef_pkg::CFG_DERIV_CUT, 32'hffffffff);
    pending_items.push_back('{32'h1, 32'h2, 32'h3, 32'd0, 1'b0});
    pending_items.push_back('{32'h80000000, 32'h7fffffff, 32'h3, 32'd7, 1'b0});
    pending_items.push_back('{32'h7fffffff, 32'h80000000, 32'h3, 32'd9, 1'b1});
    drain();
    write_reg(oef_pkg::CFG_INIT_RATE, 32'd0);
    write_reg(oef_pkg::CFG_MIN_CUTOFF, 32'd0);
    write_reg(oef_pkg::CFG_SPEED_GAIN, 32'd0);
    write_reg(oef_pkg::CFG_DERIV_CUT, 32'd0);
    pending_items.push_back('{32'h10000, 32'h20000, 32'h30000, 32'd0, 1'b0});
    pending_items.push_back('{32'h20000, 32'h10000, 32'h0, 32'd0, 1'b0});
    drain();

    // random phases under the four idling patterns with changing settings
    write_reg(oef_pkg::CFG_INIT_RATE, 32'd3932160);
    write_reg(oef_pkg::CFG_MIN_CUTOFF, 32'd65536);
    write_reg(oef_pkg::CFG_SPEED_GAIN, 32'd458);
    write_reg(oef_pkg::CFG_DERIV_CUT, 32'd65536);
    random_phase(0, 0, 220);
    write_reg(oef_pkg::CFG_SPEED_GAIN, $urandom());
    write_reg(oef_pkg::CFG_MIN_CUTOFF, $urandom_range(1, 1 << 22));
    random_phase(64, 0, 200);
    write_reg(oef_pkg::CFG_DERIV_CUT, $urandom_range(1, 1 << 24));
    write_reg(oef_pkg::CFG_INIT_RATE, $urandom_range(1, 1 << 26));
    random_phase(0, 64, 200);
    write_reg(oef_pkg::CFG_SPEED_GAIN, $urandom_range(1 << 16));
    write_reg(oef_pkg::CFG_MIN_CUTOFF, 32'd1);
    write_reg(oef_pkg::CFG_DERIV_CUT, 32'd1);

    // long receiver hold-off while items keep coming, so the input stalls
    fork
      begin
        hold_off = 1'b1;
        for (int c = 0; c < 3000; c++) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(21, 21, 210);
    join

    $display("covered %0d items, %0d checked, %0d raw pass-through, four idling patterns",
             accepted, checked, raw_seen);
    $display("register settings swept from zero to all ones, with a long output hold-off");
    if (errors == 0) begin
      $display("one_euro_filter_vec3 regression: pass");
    end else begin
      $display("one_euro_filter_vec3 regression: fail");
    end
    $finish;
  end

  // time limit for about 900 items, stalls included, with margin
  initial begin
    #40000000;
    $display("one_euro_filter_vec3 regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/oef_pkg.sv
rtl/oef_div.sv
rtl/one_euro_filter_vec3.sv
test/testbench.sv
